[design/pixel_window_scale_shift_macros.svh]
// Assertion macros shared by the pixel_window_scale_shift RTL.
// Plain text only; each macro expands to one labeled concurrent assertion.
`ifndef PIXEL_WINDOW_SCALE_SHIFT_MACROS_SVH
`define PIXEL_WINDOW_SCALE_SHIFT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pwss_pkg.sv]
// Package for pixel_window_scale_shift: widths, register indexes, pixel
// format codes and the divider pipeline payload type. No dependencies.
package pwss_pkg;

    // Stream and configuration widths
    localparam int IN_W       = 56;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Field widths
    localparam int SIZE_W   = 13;
    localparam int SIZE_MAX = 8191;
    localparam int SHIFT_W  = 13;
    localparam int SCALE_W  = 17;
    localparam int DIFF_W   = 19;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    // Pixel format codes
    localparam logic [1:0] PIX_U8  = 2'd0;
    localparam logic [1:0] PIX_S16 = 2'd1;
    localparam logic [1:0] PIX_U16 = 2'd2;
    localparam logic [1:0] PIX_RGB = 2'd3;

    localparam logic [7:0] FILL_LEVEL = 8'd127;
    localparam logic [7:0] GRAY_MAX   = 8'd255;

    // Restoring divider: 8 quotient bits, two per stage
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

    // Payload carried through the divider stages
    typedef struct packed {
        logic               fill;
        logic               rgb;
        logic               sat;
        logic [SCALE_W-1:0] rem;
        logic [7:0]         quo;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } div_t;

endpackage

[design/pwss_div_stage.sv]
// One stage of the gray-level divider pipeline: two restoring quotient bits.
// Depends on pwss_pkg and pixel_window_scale_shift_macros.svh.
`include "pixel_window_scale_shift_macros.svh"

module pwss_div_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pwss_pkg::SCALE_W-1:0]      range,
    input  logic                              in_valid,
    input  pwss_pkg::div_t                    in_data,
    output logic                              in_ready,
    output logic                              out_valid,
    output pwss_pkg::div_t                    out_data,
    input  logic                              out_ready
);
    import pwss_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    // Advance when empty or when the next stage takes our item
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift-compare-subtract, DIV_STEPS quotient bits
    always_comb
    begin
        logic [SCALE_W:0]   trial;
        logic [SCALE_W-1:0] r;
        logic [7:0]         q;
        data_next = in_data;
        r = in_data.rem;
        q = in_data.quo;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {r, 1'b0};
            if (trial >= {1'b0, range})
            begin
                r = SCALE_W'(trial - {1'b0, range});
                q = {q[6:0], 1'b1};
            end
            else
            begin
                r = trial[SCALE_W-1:0];
                q = {q[6:0], 1'b0};
            end
        end
        data_next.rem = r;
        data_next.quo = q;
    end

    // Clear valid under reset, load it on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Load payload on advance
    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

    `PWSS_ASSERT_IMPL(a_rem_below_range, clk, rst_n, valid_reg, data_reg.rem < range, "remainder not below range")
    `PWSS_ASSERT_IMPL(a_bypass_zero, clk, rst_n, valid_reg && (data_reg.sat || data_reg.fill || data_reg.rgb), (data_reg.rem == '0) && (data_reg.quo == '0), "bypassed item carries quotient")
    `PWSS_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid_reg && !out_ready, valid_reg && $stable(data_reg), "stalled stage changed")

endmodule

[design/pixel_window_scale_shift.sv]
// pixel_window_scale_shift: one display pixel per transfer; 1 pixel/cycle sustained while m_axis is ready.
// Pipeline: a pixel accepted on s_axis passes through 8 registers before it shows on m_axis:
//   input, position check, range check, 4 divider stages at 2 quotient bits each, output.
// Stalls from m_axis back up stage by stage; empty stages keep s_axis_tready high.
// Reset (rst_n low, async) empties the pipeline and loads the register defaults.
// Depends on pwss_pkg, pwss_div_stage and pixel_window_scale_shift_macros.svh.
`include "pixel_window_scale_shift_macros.svh"

module pixel_window_scale_shift #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tdata: out_col[11:0], out_row[23:12], sample[39:24], sample_green[47:40],
    //        sample_blue[55:48]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pwss_pkg::IN_W-1:0]          s_axis_tdata,
    // tdata: out_first[7:0], out_second[15:8], out_third[23:16]
    // tuser: is_fill[0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pwss_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                               m_axis_tuser,
    // Register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pwss_pkg::*;

    localparam logic [SIZE_W-1:0] W_CAP = SIZE_W'((MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_CAP = SIZE_W'((MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] W_RST = (W_CAP < SIZE_W'(4096)) ? W_CAP : SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] H_RST = (H_CAP < SIZE_W'(4096)) ? H_CAP : SIZE_W'(4096);

    // Configuration registers
    logic [1:0]          pixel_type_reg;
    logic [SCALE_W-1:0]  scale_min_reg;
    logic [SCALE_W-1:0]  scale_range_reg;
    logic [SHIFT_W-1:0]  shift_x_reg;
    logic [SHIFT_W-1:0]  shift_y_reg;
    logic [SIZE_W-1:0]   image_width_reg;
    logic [SIZE_W-1:0]   image_height_reg;

    // Clamped settings
    logic [SIZE_W-1:0]   w_eff_reg, w_eff_next;
    logic [SIZE_W-1:0]   h_eff_reg, h_eff_next;
    logic [SIZE_W:0]     sx_eff_reg, sx_eff_next;
    logic [SIZE_W:0]     sy_eff_reg, sy_eff_next;
    logic [SCALE_W-1:0]  range_eff_reg, range_eff_next;

    // Input stage
    logic                s0_valid_reg;
    logic [11:0]         s0_col_reg;
    logic [11:0]         s0_row_reg;
    logic [15:0]         s0_sample_reg;
    logic [7:0]          s0_green_reg;
    logic [7:0]          s0_blue_reg;

    // Position check stage
    logic                s1_valid_reg;
    logic                s1_fill_reg, s1_fill_next;
    logic                s1_rgb_reg;
    logic [DIFF_W-1:0]   s1_diff_reg, s1_diff_next;
    logic [7:0]          s1_blue_reg;
    logic [7:0]          s1_green_reg;
    logic [7:0]          s1_red_reg;

    // Range check stage and divider chain
    div_t                dq [0:DIV_STAGES];
    logic                dv [0:DIV_STAGES];
    logic                drdy [0:DIV_STAGES];
    logic                s2_valid_reg;
    div_t                s2_data_reg, s2_data_next;

    // Output register
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_tdata_reg, out_tdata_next;
    logic                out_fill_reg;

    logic en_out, en2, en1, en0;

    // Stage enables: advance when empty or when the next stage advances
    assign en_out        = !out_valid_reg || m_axis_tready;
    assign drdy[DIV_STAGES] = en_out;
    assign en2           = !s2_valid_reg || drdy[0];
    assign en1           = !s1_valid_reg || en2;
    assign en0           = !s0_valid_reg || en1;
    assign s_axis_tready = en0;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_fill_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_type_reg   <= PIX_U8;
            scale_min_reg    <= '0;
            scale_range_reg  <= SCALE_W'(255);
            shift_x_reg      <= '0;
            shift_y_reg      <= '0;
            image_width_reg  <= SIZE_W'(4096);
            image_height_reg <= SIZE_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PIXEL_TYPE:   pixel_type_reg   <= cfg_data[1:0];
                REG_SCALE_MIN:    scale_min_reg    <= cfg_data[SCALE_W-1:0];
                REG_SCALE_RANGE:  scale_range_reg  <= cfg_data[SCALE_W-1:0];
                REG_SHIFT_X:      shift_x_reg      <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:      shift_y_reg      <= cfg_data[SHIFT_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp sizes, shifts and range
    always_comb
    begin
        logic signed [SIZE_W+1:0] sx, sy, hi_x, lo_x, hi_y, lo_y;
        if (image_width_reg == '0)
            w_eff_next = SIZE_W'(1);
        else if (image_width_reg > W_CAP)
            w_eff_next = W_CAP;
        else
            w_eff_next = image_width_reg;
        if (image_height_reg == '0)
            h_eff_next = SIZE_W'(1);
        else if (image_height_reg > H_CAP)
            h_eff_next = H_CAP;
        else
            h_eff_next = image_height_reg;

        hi_x = $signed({2'b00, w_eff_next}) - 15'sd1;
        lo_x = 15'sd1 - $signed({2'b00, w_eff_next});
        hi_y = $signed({2'b00, h_eff_next}) - 15'sd1;
        lo_y = 15'sd1 - $signed({2'b00, h_eff_next});
        sx = $signed({{2{shift_x_reg[SHIFT_W-1]}}, shift_x_reg});
        sy = $signed({{2{shift_y_reg[SHIFT_W-1]}}, shift_y_reg});
        if (sx > hi_x)
            sx = hi_x;
        if (sx < lo_x)
            sx = lo_x;
        if (sy > hi_y)
            sy = hi_y;
        if (sy < lo_y)
            sy = lo_y;
        sx_eff_next = sx[SIZE_W:0];
        sy_eff_next = sy[SIZE_W:0];

        range_eff_next = (scale_range_reg == '0) ? SCALE_W'(1) : scale_range_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg     <= W_RST;
            h_eff_reg     <= H_RST;
            sx_eff_reg    <= '0;
            sy_eff_reg    <= '0;
            range_eff_reg <= SCALE_W'(255);
        end
        else
        begin
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            sx_eff_reg    <= sx_eff_next;
            sy_eff_reg    <= sy_eff_next;
            range_eff_reg <= range_eff_next;
        end
    end

    // Input stage: capture the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en0)
            s0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_col_reg    <= s_axis_tdata[11:0];
            s0_row_reg    <= s_axis_tdata[23:12];
            s0_sample_reg <= s_axis_tdata[39:24];
            s0_green_reg  <= s_axis_tdata[47:40];
            s0_blue_reg   <= s_axis_tdata[55:48];
        end
    end

    // Position check and offset from the black level
    always_comb
    begin
        logic signed [SIZE_W+1:0] sc, sr;
        logic                     in_x, in_y;
        logic [DIFF_W-2:0]        v;
        sc = $signed({3'b000, s0_col_reg}) - $signed({sx_eff_reg[SIZE_W], sx_eff_reg});
        sr = $signed({3'b000, s0_row_reg}) - $signed({sy_eff_reg[SIZE_W], sy_eff_reg});
        in_x = ({1'b0, s0_col_reg} < w_eff_reg) && !sc[SIZE_W+1]
               && (sc[SIZE_W:0] < {1'b0, w_eff_reg});
        in_y = ({1'b0, s0_row_reg} < h_eff_reg) && !sr[SIZE_W+1]
               && (sr[SIZE_W:0] < {1'b0, h_eff_reg});
        s1_fill_next = !(in_x && in_y);

        unique case (pixel_type_reg)
            PIX_U8:           v = {10'd0, s0_sample_reg[7:0]};
            PIX_S16:          v = {{2{s0_sample_reg[15]}}, s0_sample_reg};
            PIX_U16, PIX_RGB: v = {2'b00, s0_sample_reg};
        endcase
        s1_diff_next = {v[DIFF_W-2], v}
                       - {{2{scale_min_reg[SCALE_W-1]}}, scale_min_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_fill_reg  <= s1_fill_next;
            s1_rgb_reg   <= (pixel_type_reg == PIX_RGB);
            s1_diff_reg  <= s1_diff_next;
            s1_blue_reg  <= s0_blue_reg;
            s1_green_reg <= s0_green_reg;
            s1_red_reg   <= s0_sample_reg[7:0];
        end
    end

    // Range check: saturate, zero, or seed the divider
    always_comb
    begin
        logic pos, sat;
        pos = !s1_diff_reg[DIFF_W-1] && (s1_diff_reg != '0);
        sat = pos && (s1_diff_reg[DIFF_W-2:0] >= {1'b0, range_eff_reg});
        s2_data_next.fill  = s1_fill_reg;
        s2_data_next.rgb   = s1_rgb_reg;
        s2_data_next.sat   = sat;
        s2_data_next.rem   = (pos && !sat && !s1_fill_reg && !s1_rgb_reg)
                             ? s1_diff_reg[SCALE_W-1:0] : '0;
        s2_data_next.quo   = '0;
        s2_data_next.blue  = s1_blue_reg;
        s2_data_next.green = s1_green_reg;
        s2_data_next.red   = s1_red_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
            s2_data_reg <= s2_data_next;
    end

    assign dq[0] = s2_data_reg;
    assign dv[0] = s2_valid_reg;

    // Divider chain
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        pwss_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .range     (range_eff_reg),
            .in_valid  (dv[i]),
            .in_data   (dq[i]),
            .in_ready  (drdy[i]),
            .out_valid (dv[i+1]),
            .out_data  (dq[i+1]),
            .out_ready (drdy[i+1])
        );
    end

    // Select output bytes
    always_comb
    begin
        div_t d;
        d = dq[DIV_STAGES];
        if (d.fill)
            out_tdata_next = {FILL_LEVEL, FILL_LEVEL, FILL_LEVEL};
        else if (d.rgb)
            out_tdata_next = {d.red, d.green, d.blue};
        else if (d.sat)
            out_tdata_next = {FILL_LEVEL, FILL_LEVEL, GRAY_MAX};
        else
            out_tdata_next = {FILL_LEVEL, FILL_LEVEL, d.quo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= dv[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_tdata_reg <= out_tdata_next;
            out_fill_reg  <= dq[DIV_STAGES].fill;
        end
    end

    `PWSS_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !out_valid_reg, s_axis_tready, "input blocked with empty output")
    `PWSS_ASSERT_IMPL(a_fill_bytes, clk, rst_n, out_valid_reg && out_fill_reg, (out_tdata_reg[7:0] == FILL_LEVEL) && (out_tdata_reg[15:8] == FILL_LEVEL) && (out_tdata_reg[23:16] == FILL_LEVEL), "fill pixel not at fill level")
    `PWSS_ASSERT_IMPL(a_eff_nonzero, clk, rst_n, 1'b1, (range_eff_reg != '0) && (w_eff_reg != '0) && (h_eff_reg != '0), "clamped setting is zero")
    `PWSS_ASSERT_NEXT(a_accept_lands, clk, rst_n, s_axis_tvalid && s_axis_tready, s0_valid_reg, "accepted transfer lost at input stage")

endmodule

[sim/tb_top.sv]
// Testbench for pixel_window_scale_shift: directed table, then random phases of
// register writes and pixel streams, checked against typed-in expectations or a built-in predictor.
// Depends on pwss_pkg and the pixel_window_scale_shift RTL.
module tb_top;
    import pwss_pkg::*;

    localparam int IMG_MAX_W      = 4096;
    localparam int IMG_MAX_H      = 4096;
    localparam int RANDOM_PIXELS  = 800;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // Index past the end of the register file; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Input pixel, packed as on s_axis_tdata (out_col in the low bits)
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [15:0] sample;
        logic [11:0] row;
        logic [11:0] col;
    } pix_in_t;

    // Output pixel, packed as {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        logic       fill;
        logic [7:0] third;
        logic [7:0] second;
        logic [7:0] first;
    } pix_t;

    typedef struct {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        pix_in_t               px;
        logic                  known;
        pix_t                  want;
    } step_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    localparam pix_t FILL_PIXEL = '{fill: 1'b1, third: FILL_LEVEL, second: FILL_LEVEL,
                                    first: FILL_LEVEL};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pixel on the slave bus, with its typed-in expectation if any
    pix_in_t cur_in = '0;
    logic    cur_known = 1'b0;
    pix_t    cur_want = '0;

    // Register copies used for prediction
    logic [1:0]         pix_type    = PIX_U8;
    logic signed [16:0] black_level = '0;
    logic [16:0]        level_span  = 17'd255;
    logic signed [12:0] shift_x     = '0;
    logic signed [12:0] shift_y     = '0;
    logic [12:0]        img_w       = 13'd4096;
    logic [12:0]        img_h       = 13'd4096;

    pix_t  expected_pixels[$];
    step_t directed_steps[$];
    int    mismatch_count = 0;
    int    pixels_sent = 0;
    int    quiet_cycles = 0;

    rx_mode_t   stall_mode = RX_ALWAYS;
    int         stall_left = 0;
    logic [7:0] stall_pattern = 8'hFF;

    assign s_axis_tdata = cur_in;

    pixel_window_scale_shift #(
        .MAX_WIDTH  (IMG_MAX_W),
        .MAX_HEIGHT (IMG_MAX_H)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Image size after clamping to [1, limit]
    function automatic int clamp_dim(logic [12:0] sz, int limit);
        int s;
        s = sz;
        if (s < 1)
            s = 1;
        if (s > limit)
            s = limit;
        return s;
    endfunction

    // Shift after clamping so that at least one source pixel remains
    function automatic int clamp_offset(logic signed [12:0] sh, int sz);
        int s;
        s = sh;
        if (s > sz - 1)
            s = sz - 1;
        if (s < 1 - sz)
            s = 1 - sz;
        return s;
    endfunction

    function automatic pix_t predict_pixel(pix_in_t p);
        int   w, h, col, row, sc, sr, lvl, span, diff, q;
        pix_t r;
        w   = clamp_dim(img_w, IMG_MAX_W);
        h   = clamp_dim(img_h, IMG_MAX_H);
        col = p.col;
        row = p.row;
        sc  = col - clamp_offset(shift_x, w);
        sr  = row - clamp_offset(shift_y, h);
        r   = FILL_PIXEL;
        if (col >= w || row >= h || sc < 0 || sc >= w || sr < 0 || sr >= h)
            return r;
        r.fill = 1'b0;
        if (pix_type == PIX_RGB)
        begin
            r.first  = p.blue;
            r.second = p.green;
            r.third  = p.sample[7:0];
        end
        else
        begin
            if (pix_type == PIX_U8)
                lvl = p.sample[7:0];
            else if (pix_type == PIX_S16)
                lvl = $signed(p.sample);
            else
                lvl = p.sample;
            span = level_span;
            if (span == 0)
                span = 1;
            diff = lvl - black_level;
            q = (diff <= 0) ? 0 : (diff * 256) / span;
            if (q > 255)
                q = 255;
            r.first = q[7:0];
        end
        return r;
    endfunction

    function automatic pix_t gray_pixel(logic [7:0] lvl);
        pix_t r;
        r       = FILL_PIXEL;
        r.fill  = 1'b0;
        r.first = lvl;
        return r;
    endfunction

    function automatic pix_in_t pixel_in(int col, int row, logic [15:0] smp,
                                         logic [7:0] g, logic [7:0] b);
        pix_in_t p;
        p.col    = col[11:0];
        p.row    = row[11:0];
        p.sample = smp;
        p.green  = g;
        p.blue   = b;
        return p;
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s = '{is_write: 1'b1, reg_idx: idx, reg_val: val, px: '0, known: 1'b0, want: '0};
        directed_steps.push_back(s);
    endfunction

    function automatic void add_pixel(pix_in_t p, logic known, pix_t want);
        step_t s;
        s = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, px: p, known: known, want: want};
        directed_steps.push_back(s);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(logic [CFG_IDX_W-1:0] idx);
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 17'($urandom());
        case (idx)
            REG_PIXEL_TYPE:
                return 17'($urandom_range(0, 3));
            REG_SCALE_MIN:
                case (pick)
                    1:       return 17'h10000;
                    2:       return 17'h0FFFF;
                    3:       return 17'($urandom());
                    default: return 17'(int'($urandom_range(0, 600)) - 300);
                endcase
            REG_SCALE_RANGE:
                case (pick)
                    1:       return 17'd0;
                    2:       return 17'h1FFFF;
                    3:       return 17'd255;
                    4:       return 17'($urandom_range(1, 70000));
                    default: return 17'($urandom_range(1, 1024));
                endcase
            REG_SHIFT_X, REG_SHIFT_Y:
                case (pick)
                    1:       return 17'd4095;
                    2:       return 17'(-4095);
                    3:       return 17'($urandom());
                    default: return 17'(int'($urandom_range(0, 40)) - 20);
                endcase
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT:
                case (pick)
                    1:       return 17'd0;
                    2:       return 17'd4096;
                    3:       return 17'd8191;
                    4:       return 17'($urandom_range(1, 4096));
                    default: return 17'($urandom_range(1, 64));
                endcase
            default:
                return 17'($urandom());
        endcase
    endfunction

    // Random pixel: positions mostly inside the image, samples half the time near black
    function automatic pix_in_t random_pixel();
        pix_in_t     p;
        logic [63:0] raw;
        int          col_hi, row_hi, span;
        col_hi = clamp_dim(img_w, IMG_MAX_W);
        row_hi = clamp_dim(img_h, IMG_MAX_H);
        if (col_hi > 4095)
            col_hi = 4095;
        if (row_hi > 4095)
            row_hi = 4095;
        raw = {$urandom(), $urandom()};
        p = raw[IN_W-1:0];
        if ($urandom_range(0, 3) != 0)
        begin
            p.col = 12'($urandom_range(0, col_hi));
            p.row = 12'($urandom_range(0, row_hi));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            span = level_span;
            p.sample = 16'(black_level + int'($urandom_range(0, span + span / 4)));
        end
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PIXEL_TYPE:   pix_type    = val[1:0];
            REG_SCALE_MIN:    black_level = val;
            REG_SCALE_RANGE:  level_span  = val;
            REG_SHIFT_X:      shift_x     = val[12:0];
            REG_SHIFT_Y:      shift_y     = val[12:0];
            REG_IMAGE_WIDTH:  img_w       = val[12:0];
            REG_IMAGE_HEIGHT: img_h       = val[12:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(pix_in_t p, logic known, pix_t want);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        cur_in        <= p;
        cur_known     <= known;
        cur_want      <= want;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid, drain every expected pixel, then let the pipeline settle
    task automatic drain_pipeline();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Record expectations on accepted inputs; compare accepted outputs
    always @(posedge clk)
    begin
        pix_t oldest;
        pix_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(cur_known ? cur_want : predict_pixel(cur_in));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, got %h", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    check_field("out_first", oldest.first, got.first);
                    check_field("out_second", oldest.second, got.second);
                    check_field("out_third", oldest.third, got.third);
                    check_field("is_fill", 8'(oldest.fill), 8'(got.fill));
                end
            end
        end
    end

    // Receiver back-pressure: switch to a random stall style whenever the current one runs out
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode    <= rx_mode_t'($urandom_range(0, 3));
            stall_pattern <= 8'($urandom());
            stall_left    <= $urandom_range(50, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            RX_ALWAYS:  m_axis_tready <= 1'b1;
            RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: m_axis_tready <= stall_pattern[stall_left % 8];
            default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Abort when no transfer happens on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL pixel_window_scale_shift");
            $finish;
        end
    end

    initial
    begin
        step_t s;
        int    idx;
        int    burst_left;
        int    phase_items;
        bit    last_was_pixel;

        // Defaults after reset: unsigned byte, black 0, span 255, no shift, full size
        add_pixel(pixel_in(0, 0, 16'h0000, 8'h00, 8'h00), 1'b1, gray_pixel(8'd0));
        add_pixel(pixel_in(4095, 4095, 16'h00FF, 8'hFF, 8'hFF), 1'b1, gray_pixel(8'd255));
        // Unsigned byte ignores the high sample byte
        add_pixel(pixel_in(10, 20, 16'hFF80, 8'h00, 8'h00), 1'b1, gray_pixel(8'd128));

        // Positive and negative shifts: left, right and bottom edges
        add_write(REG_SHIFT_X, 17'd5);
        add_write(REG_SHIFT_Y, 17'h1FFFD);
        add_pixel(pixel_in(4, 0, 16'h0040, 8'h00, 8'h00), 1'b1, FILL_PIXEL);
        add_pixel(pixel_in(5, 0, 16'h0040, 8'h00, 8'h00), 1'b0, '0);
        add_pixel(pixel_in(100, 4095, 16'h0011, 8'h00, 8'h00), 1'b1, FILL_PIXEL);
        add_pixel(pixel_in(4095, 4092, 16'h00AA, 8'h00, 8'h00), 1'b0, '0);

        // Width zero acts as one, height beyond the maximum saturates
        add_write(REG_IMAGE_WIDTH, 17'd0);
        add_write(REG_IMAGE_HEIGHT, 17'd8191);
        add_pixel(pixel_in(0, 0, 16'h1234, 8'h00, 8'h00), 1'b0, '0);
        add_pixel(pixel_in(1, 0, 16'h1234, 8'h00, 8'h00), 1'b1, FILL_PIXEL);

        // Largest shifts, clamped to the size; single-row image
        add_write(REG_IMAGE_WIDTH, 17'd4096);
        add_write(REG_IMAGE_HEIGHT, 17'd1);
        add_write(REG_SHIFT_X, 17'd4095);
        add_write(REG_SHIFT_Y, 17'h1FFFF);
        add_pixel(pixel_in(4095, 0, 16'h00C3, 8'h00, 8'h00), 1'b0, '0);
        add_pixel(pixel_in(4094, 0, 16'h00C3, 8'h00, 8'h00), 1'b1, FILL_PIXEL);
        add_pixel(pixel_in(4095, 1, 16'h00C3, 8'h00, 8'h00), 1'b1, FILL_PIXEL);

        // Most negative shifts, one of them past the clamp
        add_write(REG_SHIFT_X, 17'h1F001);
        add_write(REG_IMAGE_HEIGHT, 17'd4096);
        add_write(REG_SHIFT_Y, 17'h1F000);
        add_pixel(pixel_in(0, 0, 16'h0077, 8'h00, 8'h00), 1'b0, '0);
        add_pixel(pixel_in(1, 0, 16'h0077, 8'h00, 8'h00), 1'b1, FILL_PIXEL);

        // Signed 16-bit with the widest window
        add_write(REG_PIXEL_TYPE, 17'(PIX_S16));
        add_write(REG_SCALE_MIN, 17'h10000);
        add_write(REG_SCALE_RANGE, 17'h1FFFF);
        add_pixel(pixel_in(0, 0, 16'h8000, 8'h00, 8'h00), 1'b0, '0);
        add_pixel(pixel_in(0, 0, 16'h7FFF, 8'h00, 8'h00), 1'b0, '0);

        // Zero range behaves as one: anything above black saturates
        add_write(REG_SCALE_RANGE, 17'd0);
        add_write(REG_SCALE_MIN, 17'd0);
        add_pixel(pixel_in(0, 0, 16'h8000, 8'h00, 8'h00), 1'b1, gray_pixel(8'd0));
        add_pixel(pixel_in(0, 0, 16'h0001, 8'h00, 8'h00), 1'b1, gray_pixel(8'd255));

        // Unsigned 16-bit at the top of the range
        add_write(REG_PIXEL_TYPE, 17'(PIX_U16));
        add_write(REG_SCALE_MIN, 17'h0FFFF);
        add_write(REG_SCALE_RANGE, 17'd1);
        add_pixel(pixel_in(0, 0, 16'hFFFF, 8'h00, 8'h00), 1'b1, gray_pixel(8'd0));
        add_pixel(pixel_in(0, 0, 16'hFFFE, 8'h00, 8'h00), 1'b1, gray_pixel(8'd0));

        // RGB reorder, a dropped write to a missing register, and RGB fill
        add_write(REG_PIXEL_TYPE, 17'(PIX_RGB));
        add_write(REG_UNUSED, 17'h1FFFF);
        add_pixel(pixel_in(0, 0, 16'hABCD, 8'h12, 8'h34), 1'b1,
                  '{fill: 1'b0, third: 8'hCD, second: 8'h12, first: 8'h34});
        add_pixel(pixel_in(1, 0, 16'hABCD, 8'h12, 8'h34), 1'b1, FILL_PIXEL);

        // Hold reset, then release it away from the active edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; drain before each run of register writes
        last_was_pixel = 1'b0;
        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            if (s.is_write)
            begin
                if (last_was_pixel)
                    drain_pipeline();
                write_reg(s.reg_idx, s.reg_val);
                last_was_pixel = 1'b0;
            end
            else
            begin
                send_pixel(s.px, s.known, s.want);
                last_was_pixel = 1'b1;
            end
        end

        // Random phases: new settings, then a bursty stream of pixels
        pixels_sent = 0;
        burst_left  = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            drain_pipeline();
            for (idx = REG_PIXEL_TYPE; idx <= REG_UNUSED; idx++)
                if ($urandom_range(0, 1) != 0)
                    write_reg(idx[CFG_IDX_W-1:0], random_reg_value(idx[CFG_IDX_W-1:0]));
            phase_items = $urandom_range(20, 60);
            repeat (phase_items)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    if ($urandom_range(0, 3) != 0)
                        hold_off($urandom_range(1, 6));
                end
                send_pixel(random_pixel(), 1'b0, '0);
                burst_left--;
            end
        end

        drain_pipeline();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("PASS pixel_window_scale_shift");
        else
            $display("FAIL pixel_window_scale_shift");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/pwss_pkg.sv
design/pwss_div_stage.sv
design/pixel_window_scale_shift.sv
sim/tb_top.sv
